### hw/rtl/apdc_pkg.sv
// Shared types, constants and helper functions of the arm preset drive controller.
`default_nettype none

package apdc_pkg;

  localparam int unsigned StickW   = 8;
  localparam int unsigned PosW     = 17;
  localparam int unsigned AngleW   = 11;
  localparam int unsigned CmpW     = 13;
  localparam int unsigned HeldW    = 4;
  localparam int unsigned PressW   = 6;
  localparam int unsigned DeadW    = 7;
  localparam int unsigned OverW    = 6;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 11;

  // Truncating division by 100 as multiply by reciprocal and shift; exact for magnitudes
  // up to 91179, which covers the whole position range.
  localparam int unsigned       Div100Shift = 23;
  localparam logic [PosW-1:0]   Div100Mult  = 17'd83887;

  localparam logic signed [StickW-1:0] SpeedFull = 8'sd127;
  localparam logic signed [StickW-1:0] SpeedMid  = 8'sd30;
  localparam logic signed [StickW-1:0] SpeedZero = 8'sd0;

  localparam logic [CfgIdxW-1:0] CFG_DEADBAND     = 3'd0;
  localparam logic [CfgIdxW-1:0] CFG_DOWN_ANGLE   = 3'd1;
  localparam logic [CfgIdxW-1:0] CFG_MIDDLE_ANGLE = 3'd2;
  localparam logic [CfgIdxW-1:0] CFG_UP_ANGLE     = 3'd3;
  localparam logic [CfgIdxW-1:0] CFG_FLIP_ANGLE   = 3'd4;
  localparam logic [CfgIdxW-1:0] CFG_OVERSHOOT    = 3'd5;

  localparam logic [DeadW-1:0]         RstDeadband   = 7'd8;
  localparam logic signed [AngleW-1:0] RstDownAngle  = 11'sd2;
  localparam logic signed [AngleW-1:0] RstMidAngle   = 11'sd25;
  localparam logic signed [AngleW-1:0] RstUpAngle    = 11'sd140;
  localparam logic signed [AngleW-1:0] RstFlipAngle  = 11'sd225;
  localparam logic [OverW-1:0]         RstOvershoot  = 6'd6;

  localparam int unsigned HeldIntakeOut = 0;
  localparam int unsigned HeldIntakeIn  = 1;
  localparam int unsigned HeldArmUp     = 2;
  localparam int unsigned HeldArmDown   = 3;

  localparam int unsigned PressMiddle  = 0;
  localparam int unsigned PressDown    = 1;
  localparam int unsigned PressUp      = 2;
  localparam int unsigned PressFlip    = 3;
  localparam int unsigned PressClamp   = 4;
  localparam int unsigned PressSweeper = 5;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_MID_UP = 3'd1,
    MODE_MID_DN = 3'd2,
    MODE_DOWN   = 3'd3,
    MODE_UP_UP  = 3'd4,
    MODE_UP_DN  = 3'd5,
    MODE_FL_UP  = 3'd6,
    MODE_FL_DN  = 3'd7
  } arm_mode_e;

  typedef struct packed {
    logic [DeadW-1:0]         deadband;
    logic signed [AngleW-1:0] down_angle;
    logic signed [AngleW-1:0] middle_angle;
    logic signed [AngleW-1:0] up_angle;
    logic signed [AngleW-1:0] flip_angle;
    logic [OverW-1:0]         overshoot;
  } cfg_t;

  typedef struct packed {
    logic signed [StickW-1:0] left_stick_y;
    logic signed [StickW-1:0] right_stick_x;
    logic signed [AngleW-1:0] angle;
    logic [HeldW-1:0]         held_buttons;
    logic [PressW-1:0]        new_presses;
  } item_t;

  typedef struct packed {
    logic signed [StickW-1:0] left_drive_command;
    logic signed [StickW-1:0] right_drive_command;
    logic signed [StickW-1:0] intake_command;
    logic signed [StickW-1:0] arm_command;
    logic                     arm_hold;
    logic                     clamp_engaged;
    logic                     sweeper_deployed;
  } res_t;

  function automatic logic signed [StickW-1:0] sat_cmd(input logic signed [StickW:0] v);
    logic signed [StickW-1:0] r;
    if (v > 9'sd127) begin
      r = SpeedFull;
    end else if (v < -9'sd127) begin
      r = -SpeedFull;
    end else begin
      r = v[StickW-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [StickW-1:0] dead_band(input logic signed [StickW-1:0] v,
                                                         input logic [DeadW-1:0] lim);
    logic [StickW-1:0]        mag;
    logic signed [StickW-1:0] r;
    mag = v[StickW-1] ? StickW'(-v) : v;
    r   = (mag < {1'b0, lim}) ? SpeedZero : v;
    return r;
  endfunction

  function automatic logic signed [StickW-1:0] mode_speed(input arm_mode_e m);
    logic signed [StickW-1:0] r;
    case (m)
      MODE_MID_UP: r = SpeedMid;
      MODE_MID_DN: r = -SpeedMid;
      MODE_DOWN:   r = -SpeedFull;
      MODE_UP_UP:  r = SpeedFull;
      MODE_UP_DN:  r = -SpeedFull;
      MODE_FL_UP:  r = SpeedFull;
      MODE_FL_DN:  r = -SpeedFull;
      default:     r = SpeedZero;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

### hw/rtl/apdc_cfg_regs.sv
// Configuration register file with reset values and a plain write port.
`default_nettype none

module apdc_cfg_regs (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [apdc_pkg::CfgIdxW-1:0]     cfg_idx_i,
  input  wire logic [apdc_pkg::CfgDataW-1:0]    cfg_wdata_i,
  output apdc_pkg::cfg_t                        cfg_o
);

  apdc_pkg::cfg_t cfg_q;
  apdc_pkg::cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        apdc_pkg::CFG_DEADBAND:     cfg_d.deadband     = cfg_wdata_i[apdc_pkg::DeadW-1:0];
        apdc_pkg::CFG_DOWN_ANGLE:   cfg_d.down_angle   = cfg_wdata_i;
        apdc_pkg::CFG_MIDDLE_ANGLE: cfg_d.middle_angle = cfg_wdata_i;
        apdc_pkg::CFG_UP_ANGLE:     cfg_d.up_angle     = cfg_wdata_i;
        apdc_pkg::CFG_FLIP_ANGLE:   cfg_d.flip_angle   = cfg_wdata_i;
        apdc_pkg::CFG_OVERSHOOT:    cfg_d.overshoot    = cfg_wdata_i[apdc_pkg::OverW-1:0];
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband     <= apdc_pkg::RstDeadband;
      cfg_q.down_angle   <= apdc_pkg::RstDownAngle;
      cfg_q.middle_angle <= apdc_pkg::RstMidAngle;
      cfg_q.up_angle     <= apdc_pkg::RstUpAngle;
      cfg_q.flip_angle   <= apdc_pkg::RstFlipAngle;
      cfg_q.overshoot    <= apdc_pkg::RstOvershoot;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

### hw/rtl/apdc_in_stage.sv
// Input register stage; converts the arm position to whole degrees on capture.
`default_nettype none

module apdc_in_stage (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [apdc_pkg::StickW-1:0]  left_stick_y_i,
  input  wire logic signed [apdc_pkg::StickW-1:0]  right_stick_x_i,
  input  wire logic signed [apdc_pkg::PosW-1:0]    arm_position_i,
  input  wire logic [apdc_pkg::HeldW-1:0]          held_buttons_i,
  input  wire logic [apdc_pkg::PressW-1:0]         new_presses_i,
  input  wire logic                                advance_i,
  output logic                                     valid_o,
  output apdc_pkg::item_t                          item_o
);

  logic                                      valid_q;
  logic                                      valid_d;
  apdc_pkg::item_t                           item_q;
  logic signed [apdc_pkg::PosW:0]            pos_ext;
  logic [apdc_pkg::PosW:0]                   mag_wide;
  logic [apdc_pkg::PosW-1:0]                 mag;
  logic [2*apdc_pkg::PosW-1:0]               prod;
  logic [apdc_pkg::AngleW-1:0]               quot;
  logic signed [apdc_pkg::AngleW-1:0]        angle;
  logic                                      load;

  assign in_ready_o = !valid_q || advance_i;
  assign load       = in_valid_i && in_ready_o;

  // Magnitude times the reciprocal of 100, then the sign is put back: truncates toward zero.
  assign pos_ext  = {arm_position_i[apdc_pkg::PosW-1], arm_position_i};
  assign mag_wide = arm_position_i[apdc_pkg::PosW-1] ? (apdc_pkg::PosW+1)'(-pos_ext) : pos_ext;
  assign mag      = mag_wide[apdc_pkg::PosW-1:0];
  assign prod     = mag * apdc_pkg::Div100Mult;
  assign quot     = prod[apdc_pkg::Div100Shift +: apdc_pkg::AngleW];
  assign angle    = arm_position_i[apdc_pkg::PosW-1] ? apdc_pkg::AngleW'(-quot) : quot;

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (advance_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      item_q.left_stick_y  <= left_stick_y_i;
      item_q.right_stick_x <= right_stick_x_i;
      item_q.angle         <= angle;
      item_q.held_buttons  <= held_buttons_i;
      item_q.new_presses   <= new_presses_i;
    end
  end

  assign valid_o = valid_q;
  assign item_o  = item_q;

endmodule

`default_nettype wire

### hw/rtl/apdc_tick_logic.sv
// Combinational tick logic: drive mixing, intake, arm mode decision and piston toggles.
`default_nettype none

module apdc_tick_logic (
  input  apdc_pkg::item_t     item_i,
  input  apdc_pkg::cfg_t      cfg_i,
  input  apdc_pkg::arm_mode_e mode_i,
  input  wire logic           clamp_i,
  input  wire logic           sweeper_i,
  output apdc_pkg::arm_mode_e mode_o,
  output apdc_pkg::res_t      res_o
);

  logic signed [apdc_pkg::StickW-1:0] y;
  logic signed [apdc_pkg::StickW-1:0] x;
  logic signed [apdc_pkg::StickW:0]   sum;
  logic signed [apdc_pkg::StickW:0]   diff;
  logic signed [apdc_pkg::CmpW-1:0]   ang;
  logic signed [apdc_pkg::CmpW-1:0]   mid;
  logic signed [apdc_pkg::CmpW-1:0]   dwn;
  logic signed [apdc_pkg::CmpW-1:0]   upa;
  logic signed [apdc_pkg::CmpW-1:0]   flp;
  logic signed [apdc_pkg::CmpW-1:0]   ov;
  logic signed [apdc_pkg::CmpW-1:0]   ov3;
  logic [apdc_pkg::OverW+1:0]         ov3_raw;
  logic [apdc_pkg::HeldW-1:0]         held;
  logic [apdc_pkg::PressW-1:0]        press;
  apdc_pkg::arm_mode_e                m;
  logic signed [apdc_pkg::StickW-1:0] arm;
  logic signed [apdc_pkg::StickW-1:0] intake;

  assign held  = item_i.held_buttons;
  assign press = item_i.new_presses;

  assign y    = apdc_pkg::dead_band(item_i.left_stick_y, cfg_i.deadband);
  assign x    = apdc_pkg::dead_band(item_i.right_stick_x, cfg_i.deadband);
  assign sum  = {y[apdc_pkg::StickW-1], y} + {x[apdc_pkg::StickW-1], x};
  assign diff = {y[apdc_pkg::StickW-1], y} - {x[apdc_pkg::StickW-1], x};

  assign ang     = apdc_pkg::CmpW'(item_i.angle);
  assign mid     = apdc_pkg::CmpW'(cfg_i.middle_angle);
  assign dwn     = apdc_pkg::CmpW'(cfg_i.down_angle);
  assign upa     = apdc_pkg::CmpW'(cfg_i.up_angle);
  assign flp     = apdc_pkg::CmpW'(cfg_i.flip_angle);
  assign ov      = $signed(apdc_pkg::CmpW'(cfg_i.overshoot));
  assign ov3_raw = {1'b0, cfg_i.overshoot, 1'b0} + {2'b00, cfg_i.overshoot};
  assign ov3     = $signed(apdc_pkg::CmpW'(ov3_raw));

  always_comb begin
    if (held[apdc_pkg::HeldIntakeOut]) begin
      intake = -apdc_pkg::SpeedFull;
    end else if (held[apdc_pkg::HeldIntakeIn]) begin
      intake = apdc_pkg::SpeedFull;
    end else begin
      intake = apdc_pkg::SpeedZero;
    end
  end

  // Priority chain: manual buttons, then each preset's press before its stop test.
  always_comb begin
    m = mode_i;
    if (held[apdc_pkg::HeldArmUp] || held[apdc_pkg::HeldArmDown]) begin
      m = apdc_pkg::MODE_IDLE;
    end else if (press[apdc_pkg::PressMiddle]) begin
      if (ang < mid) begin
        m = apdc_pkg::MODE_MID_UP;
      end else if (ang > mid) begin
        m = apdc_pkg::MODE_MID_DN;
      end
    end else if (mode_i == apdc_pkg::MODE_MID_UP) begin
      if (ang >= mid - ov) m = apdc_pkg::MODE_IDLE;
    end else if (mode_i == apdc_pkg::MODE_MID_DN) begin
      if (ang <= mid + ov) m = apdc_pkg::MODE_IDLE;
    end else if (press[apdc_pkg::PressDown]) begin
      m = apdc_pkg::MODE_DOWN;
    end else if (mode_i == apdc_pkg::MODE_DOWN) begin
      if (ang <= dwn + ov3) m = apdc_pkg::MODE_IDLE;
    end else if (press[apdc_pkg::PressUp]) begin
      m = (ang < upa) ? apdc_pkg::MODE_UP_UP : apdc_pkg::MODE_UP_DN;
    end else if (mode_i == apdc_pkg::MODE_UP_UP) begin
      if (ang >= upa - ov3) m = apdc_pkg::MODE_IDLE;
    end else if (mode_i == apdc_pkg::MODE_UP_DN) begin
      if (ang <= upa + ov3) m = apdc_pkg::MODE_IDLE;
    end else if (press[apdc_pkg::PressFlip]) begin
      m = (ang <= flp) ? apdc_pkg::MODE_FL_UP : apdc_pkg::MODE_FL_DN;
    end else if (mode_i == apdc_pkg::MODE_FL_UP) begin
      if (ang >= flp - ov3) m = apdc_pkg::MODE_IDLE;
    end else if (mode_i == apdc_pkg::MODE_FL_DN) begin
      if (ang <= flp + ov3) m = apdc_pkg::MODE_IDLE;
    end else begin
      m = apdc_pkg::MODE_IDLE;
    end
  end

  always_comb begin
    if (held[apdc_pkg::HeldArmUp]) begin
      arm = apdc_pkg::SpeedFull;
    end else if (held[apdc_pkg::HeldArmDown]) begin
      arm = -apdc_pkg::SpeedFull;
    end else begin
      arm = apdc_pkg::mode_speed(m);
    end
  end

  assign mode_o = m;

  assign res_o.left_drive_command  = apdc_pkg::sat_cmd(sum);
  assign res_o.right_drive_command = apdc_pkg::sat_cmd(diff);
  assign res_o.intake_command      = intake;
  assign res_o.arm_command         = arm;
  assign res_o.arm_hold            = (arm == apdc_pkg::SpeedZero);
  assign res_o.clamp_engaged       = clamp_i ^ press[apdc_pkg::PressClamp];
  assign res_o.sweeper_deployed    = sweeper_i ^ press[apdc_pkg::PressSweeper];

endmodule

`default_nettype wire

### hw/rtl/arm_preset_drive_controller_core.sv
// Top level of the arm preset drive controller: input stage, tick logic, state and result register.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+---------------------------------------------
//  in       | in_valid_i / in_ready_o      | sticks, arm position, held buttons, presses
//  out      | out_valid_o / out_ready_i    | drive, intake and arm commands, hold, pistons
//  cfg      | cfg_we_i (no back-pressure)  | cfg_idx_i, cfg_wdata_i
//
// One item per cycle unless out_ready_i stalls; each item passes the input and result registers.
// The arm mode and piston state update in the cycle the item moves into the result register.
// A stall holds the input stage; only an empty stage takes one more item before in_ready_o drops.
// Reset leaves both stages empty, the arm mode idle, the clamp engaged and the sweeper retracted.
`default_nettype none

module arm_preset_drive_controller_core (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_we_i,
  input  wire logic [apdc_pkg::CfgIdxW-1:0]        cfg_idx_i,
  input  wire logic [apdc_pkg::CfgDataW-1:0]       cfg_wdata_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [apdc_pkg::StickW-1:0]  left_stick_y_i,
  input  wire logic signed [apdc_pkg::StickW-1:0]  right_stick_x_i,
  input  wire logic signed [apdc_pkg::PosW-1:0]    arm_position_i,
  input  wire logic [apdc_pkg::HeldW-1:0]          held_buttons_i,
  input  wire logic [apdc_pkg::PressW-1:0]         new_presses_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed [apdc_pkg::StickW-1:0]       left_drive_command_o,
  output logic signed [apdc_pkg::StickW-1:0]       right_drive_command_o,
  output logic signed [apdc_pkg::StickW-1:0]       intake_command_o,
  output logic signed [apdc_pkg::StickW-1:0]       arm_command_o,
  output logic                                     arm_hold_o,
  output logic                                     clamp_engaged_o,
  output logic                                     sweeper_deployed_o
);

  apdc_pkg::cfg_t      cfg;
  apdc_pkg::item_t     item;
  apdc_pkg::res_t      res;
  apdc_pkg::res_t      res_q;
  apdc_pkg::arm_mode_e mode_q;
  apdc_pkg::arm_mode_e mode_d;
  logic                clamp_q;
  logic                sweeper_q;
  logic                stage_valid;
  logic                advance;
  logic                fire;
  logic                out_valid_q;
  logic                out_valid_d;

  assign advance = !out_valid_q || out_ready_i;
  assign fire    = stage_valid && advance;

  apdc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  apdc_in_stage u_in_stage (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .left_stick_y_i  (left_stick_y_i),
    .right_stick_x_i (right_stick_x_i),
    .arm_position_i  (arm_position_i),
    .held_buttons_i  (held_buttons_i),
    .new_presses_i   (new_presses_i),
    .advance_i       (advance),
    .valid_o         (stage_valid),
    .item_o          (item)
  );

  apdc_tick_logic u_tick_logic (
    .item_i    (item),
    .cfg_i     (cfg),
    .mode_i    (mode_q),
    .clamp_i   (clamp_q),
    .sweeper_i (sweeper_q),
    .mode_o    (mode_d),
    .res_o     (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (fire) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      mode_q      <= apdc_pkg::MODE_IDLE;
      clamp_q     <= 1'b1;
      sweeper_q   <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        mode_q    <= mode_d;
        clamp_q   <= res.clamp_engaged;
        sweeper_q <= res.sweeper_deployed;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign left_drive_command_o  = res_q.left_drive_command;
  assign right_drive_command_o = res_q.right_drive_command;
  assign intake_command_o      = res_q.intake_command;
  assign arm_command_o         = res_q.arm_command;
  assign arm_hold_o            = res_q.arm_hold;
  assign clamp_engaged_o       = res_q.clamp_engaged;
  assign sweeper_deployed_o    = res_q.sweeper_deployed;

  a_state_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !fire |=> ($stable(mode_q) && $stable(clamp_q) && $stable(sweeper_q)))
    else $error("Arm mode or piston state changed without a transfer into the result register.");

  a_hold_matches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (arm_hold_o == (arm_command_o == apdc_pkg::SpeedZero)))
    else $error("Brake hold disagrees with the arm command.");

  a_pistons_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (clamp_engaged_o == clamp_q && sweeper_deployed_o == sweeper_q))
    else $error("Piston outputs disagree with the stored piston state.");

  a_intake_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (intake_command_o == apdc_pkg::SpeedFull ||
                     intake_command_o == apdc_pkg::SpeedZero ||
                     intake_command_o == -apdc_pkg::SpeedFull))
    else $error("Intake command is not one of its three levels.");

  a_no_min_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (left_drive_command_o != -8'sd128 && right_drive_command_o != -8'sd128 &&
                     arm_command_o != -8'sd128))
    else $error("A motor command escaped saturation.");

endmodule

`default_nettype wire

### dv/arm_preset_drive_controller_core_tb.sv
// Self-checking testbench for the arm preset drive controller core.
`timescale 1ns / 1ps

module arm_preset_drive_controller_core_tb;
  import apdc_pkg::*;

  localparam int StallLimit    = 2000;
  localparam int SettleCycles  = 4;
  localparam int DrainCycles   = 8;
  localparam int NumPhases     = 6;
  localparam int ItemsPerPhase = 88;

  localparam logic [CfgIdxW-1:0] CfgIdxSpareLo = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgIdxSpareHi = 3'd7;

  localparam int HdOut     = 1 << HeldIntakeOut;
  localparam int HdIn      = 1 << HeldIntakeIn;
  localparam int HdUp      = 1 << HeldArmUp;
  localparam int HdDown    = 1 << HeldArmDown;
  localparam int PrMiddle  = 1 << PressMiddle;
  localparam int PrDown    = 1 << PressDown;
  localparam int PrUp      = 1 << PressUp;
  localparam int PrFlip    = 1 << PressFlip;
  localparam int PrClamp   = 1 << PressClamp;
  localparam int PrSweeper = 1 << PressSweeper;

  typedef struct packed {
    logic signed [StickW-1:0] stick_y;
    logic signed [StickW-1:0] stick_x;
    logic signed [PosW-1:0]   position;
    logic [HeldW-1:0]         held;
    logic [PressW-1:0]        presses;
  } tick_t;

  typedef struct {
    tick_t stim;
    bit    typed;
    res_t  want;
  } directed_row_t;

  localparam res_t Predicted = '0;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]       cfg_idx_i = '0;
  logic [CfgDataW-1:0]      cfg_wdata_i = '0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic signed [StickW-1:0] left_stick_y_i = '0;
  logic signed [StickW-1:0] right_stick_x_i = '0;
  logic signed [PosW-1:0]   arm_position_i = '0;
  logic [HeldW-1:0]         held_buttons_i = '0;
  logic [PressW-1:0]        new_presses_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b1;
  logic signed [StickW-1:0] left_drive_command_o;
  logic signed [StickW-1:0] right_drive_command_o;
  logic signed [StickW-1:0] intake_command_o;
  logic signed [StickW-1:0] arm_command_o;
  logic                     arm_hold_o;
  logic                     clamp_engaged_o;
  logic                     sweeper_deployed_o;

  arm_preset_drive_controller_core uut (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_wdata_i           (cfg_wdata_i),
    .in_valid_i            (in_valid_i),
    .in_ready_o            (in_ready_o),
    .left_stick_y_i        (left_stick_y_i),
    .right_stick_x_i       (right_stick_x_i),
    .arm_position_i        (arm_position_i),
    .held_buttons_i        (held_buttons_i),
    .new_presses_i         (new_presses_i),
    .out_valid_o           (out_valid_o),
    .out_ready_i           (out_ready_i),
    .left_drive_command_o  (left_drive_command_o),
    .right_drive_command_o (right_drive_command_o),
    .intake_command_o      (intake_command_o),
    .arm_command_o         (arm_command_o),
    .arm_hold_o            (arm_hold_o),
    .clamp_engaged_o       (clamp_engaged_o),
    .sweeper_deployed_o    (sweeper_deployed_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  logic [DeadW-1:0] deadband_q  = RstDeadband;
  int               down_q      = int'(RstDownAngle);
  int               mid_q       = int'(RstMidAngle);
  int               up_q        = int'(RstUpAngle);
  int               flip_q      = int'(RstFlipAngle);
  logic [OverW-1:0] overshoot_q = RstOvershoot;
  arm_mode_e        arm_mode_q  = MODE_IDLE;
  logic             clamp_q     = 1'b1;
  logic             sweeper_q   = 1'b0;

  res_t                     pending_cmds[$];
  directed_row_t            directed_rows[$];
  int                       mismatches = 0;
  int                       results_seen = 0;
  int                       ticks_sent = 0;
  int                       idle_pct = 20;
  logic signed [StickW-1:0] last_arm = '0;

  function automatic logic signed [StickW-1:0] clip_cmd(input int v);
    int lim;
    lim = int'(SpeedFull);
    if (v > lim) begin
      return SpeedFull;
    end else if (v < -lim) begin
      return -SpeedFull;
    end
    return StickW'(v);
  endfunction

  function automatic int gate_stick(input logic signed [StickW-1:0] v);
    int s;
    s = int'(v);
    if ((s < 0 ? -s : s) < int'(deadband_q)) begin
      s = 0;
    end
    return s;
  endfunction

  function automatic res_t next_commands(input tick_t t);
    int        y;
    int        x;
    int        ang;
    int        ov;
    int        ov3;
    int        spd;
    bit        manual;
    arm_mode_e m;
    res_t      r;
    y      = gate_stick(t.stick_y);
    x      = gate_stick(t.stick_x);
    ang    = int'(t.position) / 100;
    ov     = int'(overshoot_q);
    ov3    = 3 * ov;
    manual = 1'b0;
    spd    = 0;
    m      = arm_mode_q;

    if (t.held[HeldIntakeOut]) begin
      r.intake_command = -SpeedFull;
    end else if (t.held[HeldIntakeIn]) begin
      r.intake_command = SpeedFull;
    end else begin
      r.intake_command = SpeedZero;
    end

    if (t.held[HeldArmUp]) begin
      manual = 1'b1;
      spd    = int'(SpeedFull);
      m      = MODE_IDLE;
    end else if (t.held[HeldArmDown]) begin
      manual = 1'b1;
      spd    = -int'(SpeedFull);
      m      = MODE_IDLE;
    end else if (t.presses[PressMiddle]) begin
      if (ang < mid_q) begin
        m = MODE_MID_UP;
      end else if (ang > mid_q) begin
        m = MODE_MID_DN;
      end
    end else if (m == MODE_MID_UP) begin
      if (ang >= mid_q - ov) m = MODE_IDLE;
    end else if (m == MODE_MID_DN) begin
      if (ang <= mid_q + ov) m = MODE_IDLE;
    end else if (t.presses[PressDown]) begin
      m = MODE_DOWN;
    end else if (m == MODE_DOWN) begin
      if (ang <= down_q + ov3) m = MODE_IDLE;
    end else if (t.presses[PressUp]) begin
      m = (ang < up_q) ? MODE_UP_UP : MODE_UP_DN;
    end else if (m == MODE_UP_UP) begin
      if (ang >= up_q - ov3) m = MODE_IDLE;
    end else if (m == MODE_UP_DN) begin
      if (ang <= up_q + ov3) m = MODE_IDLE;
    end else if (t.presses[PressFlip]) begin
      m = (ang <= flip_q) ? MODE_FL_UP : MODE_FL_DN;
    end else if (m == MODE_FL_UP) begin
      if (ang >= flip_q - ov3) m = MODE_IDLE;
    end else if (m == MODE_FL_DN) begin
      if (ang <= flip_q + ov3) m = MODE_IDLE;
    end else begin
      m = MODE_IDLE;
    end
    arm_mode_q = m;

    if (!manual) begin
      case (m)
        MODE_MID_UP:                       spd = int'(SpeedMid);
        MODE_MID_DN:                       spd = -int'(SpeedMid);
        MODE_UP_UP, MODE_FL_UP:            spd = int'(SpeedFull);
        MODE_DOWN, MODE_UP_DN, MODE_FL_DN: spd = -int'(SpeedFull);
        default:                           spd = 0;
      endcase
    end
    r.arm_command = clip_cmd(spd);
    r.arm_hold    = (r.arm_command == SpeedZero);

    if (t.presses[PressClamp]) clamp_q = ~clamp_q;
    if (t.presses[PressSweeper]) sweeper_q = ~sweeper_q;

    r.left_drive_command  = clip_cmd(y + x);
    r.right_drive_command = clip_cmd(y - x);
    r.clamp_engaged       = clamp_q;
    r.sweeper_deployed    = sweeper_q;
    return r;
  endfunction

  function automatic res_t cmds(input int l, input int rr, input int in, input int a,
                                input bit h, input bit c, input bit s);
    res_t r;
    r.left_drive_command  = StickW'(l);
    r.right_drive_command = StickW'(rr);
    r.intake_command      = StickW'(in);
    r.arm_command         = StickW'(a);
    r.arm_hold            = h;
    r.clamp_engaged       = c;
    r.sweeper_deployed    = s;
    return r;
  endfunction

  function automatic directed_row_t tab_row(input int y, input int x, input int pos,
                                            input int held, input int press,
                                            input bit typed, input res_t want);
    directed_row_t d;
    d.stim.stick_y  = StickW'(y);
    d.stim.stick_x  = StickW'(x);
    d.stim.position = PosW'(pos);
    d.stim.held     = HeldW'(held);
    d.stim.presses  = PressW'(press);
    d.typed         = typed;
    d.want          = want;
    return d;
  endfunction

  function automatic logic signed [StickW-1:0] rand_stick();
    int d;
    d = int'(deadband_q);
    if ($urandom_range(0, 1) == 0) begin
      return StickW'($urandom);
    end
    return StickW'(int'($urandom_range(0, 2 * d + 4)) - (d + 2));
  endfunction

  function automatic int fit_position(input int p);
    if (p > 65535) return 65535;
    if (p < -65536) return -65536;
    return p;
  endfunction

  task automatic send_tick(input tick_t t, input bit typed, input res_t want);
    int   gap;
    res_t r;
    gap = 0;
    if ($urandom_range(0, 99) < idle_pct) begin
      gap = $urandom_range(1, 6);
    end
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    left_stick_y_i  <= t.stick_y;
    right_stick_x_i <= t.stick_x;
    arm_position_i  <= t.position;
    held_buttons_i  <= t.held;
    new_presses_i   <= t.presses;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    r        = next_commands(t);
    last_arm = r.arm_command;
    pending_cmds.push_back(typed ? want : r);
    ticks_sent++;
  endtask

  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  task automatic set_register(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DEADBAND:     deadband_q  = data[DeadW-1:0];
      CFG_DOWN_ANGLE:   down_q      = int'($signed(data));
      CFG_MIDDLE_ANGLE: mid_q       = int'($signed(data));
      CFG_UP_ANGLE:     up_q        = int'($signed(data));
      CFG_FLIP_ANGLE:   flip_q      = int'($signed(data));
      CFG_OVERSHOOT:    overshoot_q = data[OverW-1:0];
      default:          ;
    endcase
  endtask

  task automatic load_setting(input int dz, input int dn, input int md, input int upa,
                              input int fl, input int ov);
    set_register(CFG_DEADBAND, {(CfgDataW - DeadW)'($urandom), DeadW'(dz)});
    set_register(CFG_DOWN_ANGLE, CfgDataW'(dn));
    set_register(CFG_MIDDLE_ANGLE, CfgDataW'(md));
    set_register(CFG_UP_ANGLE, CfgDataW'(upa));
    set_register(CFG_FLIP_ANGLE, CfgDataW'(fl));
    set_register(CFG_OVERSHOOT, {(CfgDataW - OverW)'($urandom), OverW'(ov)});
    set_register(CfgIdxSpareLo, CfgDataW'($urandom));
    set_register(CfgIdxSpareHi, CfgDataW'($urandom));
  endtask

  task automatic compare_field(input string name, input logic signed [StickW-1:0] want,
                               input logic signed [StickW-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  initial begin
    forever begin
      if (rst_ni && $urandom_range(0, 99) < idle_pct) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (pending_cmds.size() == 0) begin
        $error("Result transfer with no tick outstanding");
        mismatches++;
      end else begin
        want = pending_cmds.pop_front();
        compare_field("left_drive_command", want.left_drive_command, left_drive_command_o);
        compare_field("right_drive_command", want.right_drive_command, right_drive_command_o);
        compare_field("intake_command", want.intake_command, intake_command_o);
        compare_field("arm_command", want.arm_command, arm_command_o);
        compare_field("arm_hold", {7'd0, want.arm_hold}, {7'd0, arm_hold_o});
        compare_field("clamp_engaged", {7'd0, want.clamp_engaged}, {7'd0, clamp_engaged_o});
        compare_field("sweeper_deployed", {7'd0, want.sweeper_deployed},
                      {7'd0, sweeper_deployed_o});
      end
    end
  end

  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("No transfer on either channel for %0d cycles", StallLimit);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int    idle_tab[NumPhases];
    int    directed_count;
    int    preset_runs;
    int    run_left;
    int    sim_pos;
    int    sel;
    int    target;
    tick_t t;

    idle_tab    = '{25, 0, 40, 15, 50, 0};
    preset_runs = 0;
    run_left    = 0;
    sim_pos     = 0;

    directed_rows.push_back(tab_row(0, 0, 0, 0, 0, 1, cmds(0, 0, 0, 0, 1, 1, 0)));
    directed_rows.push_back(tab_row(127, 127, 0, 0, 0, 1, cmds(127, 0, 0, 0, 1, 1, 0)));
    directed_rows.push_back(tab_row(-128, 127, 0, 0, 0, 1, cmds(-1, -127, 0, 0, 1, 1, 0)));
    directed_rows.push_back(tab_row(-128, -128, 0, 0, 0, 1, cmds(-127, 0, 0, 0, 1, 1, 0)));
    directed_rows.push_back(tab_row(7, -7, 0, 0, 0, 1, cmds(0, 0, 0, 0, 1, 1, 0)));
    directed_rows.push_back(tab_row(8, -8, 0, 0, 0, 1, cmds(0, 16, 0, 0, 1, 1, 0)));
    directed_rows.push_back(tab_row(0, 0, 0, HdOut | HdIn | HdUp | HdDown, 0, 1,
                                    cmds(0, 0, -127, 127, 0, 1, 0)));
    directed_rows.push_back(tab_row(0, 0, 0, HdIn | HdDown, 0, 1,
                                    cmds(0, 0, 127, -127, 0, 1, 0)));
    directed_rows.push_back(tab_row(0, 0, 0, 0, PrClamp, 1, cmds(0, 0, 0, 0, 1, 0, 0)));
    directed_rows.push_back(tab_row(0, 0, 0, 0, PrClamp | PrSweeper, 1,
                                    cmds(0, 0, 0, 0, 1, 1, 1)));
    directed_rows.push_back(tab_row(0, 0, 2599, 0, PrMiddle, 1, cmds(0, 0, 0, 0, 1, 1, 1)));
    directed_rows.push_back(tab_row(0, 0, -65536, 0, PrMiddle, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 1900, 0, 0, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 65535, 0, PrMiddle, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 3100, 0, 0, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 10000, 0, PrDown, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 2000, 0, 0, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 0, 0, PrUp, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 12200, 0, 0, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 20000, 0, PrUp, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 15800, 0, 0, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 22500, 0, PrFlip, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 22500, 0, 0, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 30000, 0, PrFlip, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 24300, 0, 0, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, -150, 0, 63, 0, Predicted));
    directed_rows.push_back(tab_row(0, 0, 0, HdUp, 0, 1, cmds(0, 0, 0, 127, 0, 0, 0)));
    directed_count = directed_rows.size();

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      send_tick(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
    end

    for (int ph = 0; ph < NumPhases; ph++) begin
      quiesce();
      case (ph)
        0: load_setting(0, -655, 0, 655, 655, 0);
        1: load_setting(127, -1024, 1023, -1024, 1023, 63);
        5: load_setting(int'(RstDeadband), int'(RstDownAngle), int'(RstMidAngle),
                        int'(RstUpAngle), int'(RstFlipAngle), int'(RstOvershoot));
        default: load_setting($urandom_range(0, 30), int'($urandom_range(0, 1310)) - 655,
                              int'($urandom_range(0, 1310)) - 655,
                              int'($urandom_range(0, 1310)) - 655,
                              int'($urandom_range(0, 1310)) - 655, $urandom_range(0, 63));
      endcase
      idle_pct = idle_tab[ph];

      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (n == ItemsPerPhase / 2) begin
          quiesce();
        end
        if (run_left > 0) begin
          // Follow the arm as it moves under its own command until the run of ticks ends.
          run_left--;
          if (last_arm > 0) begin
            sim_pos = fit_position(sim_pos + int'($urandom_range(0, 900)));
          end else if (last_arm < 0) begin
            sim_pos = fit_position(sim_pos - int'($urandom_range(0, 900)));
          end
          t.held    = {2'b00, 2'($urandom)};
          t.presses = {2'($urandom), 4'b0000};
          if ($urandom_range(0, 19) == 0) begin
            t.held    = HeldW'($urandom);
            t.presses = PressW'($urandom);
          end
        end else if ($urandom_range(0, 9) < 7) begin
          sel       = $urandom_range(0, 3);
          t.presses = {2'($urandom), 4'b0000};
          t.presses[sel] = 1'b1;
          if ($urandom_range(0, 4) == 0) begin
            t.presses[3:0] = t.presses[3:0] | 4'($urandom);
          end
          case (sel)
            PressMiddle: target = mid_q;
            PressDown:   target = down_q;
            PressUp:     target = up_q;
            default:     target = flip_q;
          endcase
          if ($urandom_range(0, 3) == 0) begin
            sim_pos = int'($urandom_range(0, 131071)) - 65536;
          end else begin
            sim_pos = fit_position(target * 100 + int'($urandom_range(0, 12000)) - 6000);
          end
          t.held   = {2'b00, 2'($urandom)};
          run_left = $urandom_range(2, 30);
          preset_runs++;
        end else begin
          sim_pos   = int'($urandom_range(0, 131071)) - 65536;
          t.held    = HeldW'($urandom);
          t.presses = PressW'($urandom);
        end
        t.position = PosW'(sim_pos);
        t.stick_y  = rand_stick();
        t.stick_x  = rand_stick();
        send_tick(t, 1'b0, Predicted);
      end
    end

    in_valid_i <= 1'b0;
    while (pending_cmds.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Sent %0d control ticks (%0d from the directed table) under %0d register settings.",
             ticks_sent, directed_count, NumPhases + 1);
    $display("Checked %0d results; the random part started %0d preset runs.",
             results_seen, preset_runs);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
